// ===== rtl/stp_pkg.sv =====
`default_nettype none
package stp_pkg;

  // field widths fixed by the stream format
  localparam int STEPS_W  = 24;
  localparam int PERIOD_W = 20;
  localparam int PULSE_W  = 8;
  localparam int CFG_IDX_W = 1;

  // default sizing of the internal counters
  localparam int COUNT_WIDTH_DEF = 24;
  localparam int TIMER_WIDTH_DEF = 20;

  // reset values of the configuration registers
  localparam logic [PERIOD_W-1:0] STEP_PERIOD_RST = PERIOD_W'(1000);
  localparam logic [PULSE_W-1:0]  PULSE_WIDTH_RST = PULSE_W'(3);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_WIDTH = 1'b1;

  // operation codes carried in tuser
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_MOVE = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_STEP = 2'd2
  } phase_t;

  typedef struct packed {
    logic                      step_level;
    logic                      dir_level;
    logic                      done_res;
    logic signed [STEPS_W-1:0] steps_gone;
  } stp_result_t;

endpackage
`default_nettype wire

// ===== rtl/stp_core.sv =====
`default_nettype none
module stp_core import stp_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      item_valid,
  input  wire logic                      item_op,
  input  wire logic signed [STEPS_W-1:0] item_steps,
  input  wire logic [PERIOD_W-1:0]       step_period,
  input  wire logic [PULSE_W-1:0]        pulse_width,
  output stp_result_t                    res
);

  localparam int MAG_W = COUNT_WIDTH - 1;
  localparam int SUM_W = ((COUNT_WIDTH > STEPS_W) ? COUNT_WIDTH : STEPS_W) + 1;
  localparam int CMP_W = (TIMER_WIDTH > PERIOD_W) ? TIMER_WIDTH : PERIOD_W;
  localparam int GW    = (COUNT_WIDTH > STEPS_W) ? COUNT_WIDTH : STEPS_W;

  phase_t                 phase, phase_next;
  logic [MAG_W-1:0]       target_magnitude, target_magnitude_next;
  logic [MAG_W-1:0]       completed_steps, completed_steps_next;
  logic                   direction_positive, direction_positive_next;
  logic                   last_direction_positive, last_direction_positive_next;
  logic [TIMER_WIDTH-1:0] tick_timer, tick_timer_next;

  logic [MAG_W-1:0]        rem;
  logic signed [SUM_W-1:0] rem_s, merged, merged_sat, limit;
  logic [SUM_W-1:0]        abs_merged;
  logic [MAG_W-1:0]        mag;
  logic [TIMER_WIDTH-1:0]  t_inc;
  logic [CMP_W-1:0]        period_x;
  logic                    step_end;
  logic [MAG_W-1:0]        completed_inc;
  logic signed [COUNT_WIDTH-1:0] gone_c;
  logic signed [GW-1:0]    gone_x;

  // merge of a move with what is still pending
  always_comb begin
    rem   = (target_magnitude > completed_steps) ? (target_magnitude - completed_steps) : '0;
    rem_s = signed'(SUM_W'(rem));
    limit = signed'(SUM_W'({MAG_W{1'b1}}));
    if (phase == PH_IDLE) begin
      merged = SUM_W'(item_steps);
    end else if (direction_positive) begin
      merged = rem_s + SUM_W'(item_steps);
    end else begin
      merged = -rem_s + SUM_W'(item_steps);
    end
    if (merged > limit) begin
      merged_sat = limit;
    end else if (merged < -limit) begin
      merged_sat = -limit;
    end else begin
      merged_sat = merged;
    end
    abs_merged = merged_sat[SUM_W-1] ? unsigned'(-merged_sat) : unsigned'(merged_sat);
    mag        = abs_merged[MAG_W-1:0];
  end

  // tick timing
  always_comb begin
    t_inc         = tick_timer + 1'b1;
    period_x      = (step_period == '0) ? CMP_W'(1) : CMP_W'(step_period);
    step_end      = (CMP_W'(t_inc) >= period_x) || (t_inc == '0);
    completed_inc = completed_steps + 1'b1;
  end

  always_comb begin
    phase_next                   = phase;
    target_magnitude_next        = target_magnitude;
    completed_steps_next         = completed_steps;
    direction_positive_next      = direction_positive;
    last_direction_positive_next = last_direction_positive;
    tick_timer_next              = tick_timer;
    if (item_valid) begin
      if (item_op == OP_MOVE) begin
        if (item_steps != '0) begin
          direction_positive_next = (merged_sat > 0);
          target_magnitude_next   = mag;
          completed_steps_next    = '0;
          tick_timer_next         = '0;
          if (mag == '0) begin
            phase_next = PH_IDLE;
          end else if (last_direction_positive != (merged_sat > 0)) begin
            phase_next = PH_WAIT;
          end else begin
            phase_next = PH_STEP;
          end
        end
      end else begin
        case (phase)
          PH_WAIT: begin
            if (step_end) begin
              tick_timer_next              = '0;
              last_direction_positive_next = direction_positive;
              phase_next                   = PH_STEP;
            end else begin
              tick_timer_next = t_inc;
            end
          end
          PH_STEP: begin
            if (step_end) begin
              tick_timer_next      = '0;
              completed_steps_next = completed_inc;
              if (completed_inc >= target_magnitude) begin
                phase_next = PH_IDLE;
              end
            end else begin
              tick_timer_next = t_inc;
            end
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase                   <= PH_IDLE;
      target_magnitude        <= '0;
      completed_steps         <= '0;
      direction_positive      <= 1'b1;
      last_direction_positive <= 1'b1;
      tick_timer              <= '0;
    end else begin
      phase                   <= phase_next;
      target_magnitude        <= target_magnitude_next;
      completed_steps         <= completed_steps_next;
      direction_positive      <= direction_positive_next;
      last_direction_positive <= last_direction_positive_next;
      tick_timer              <= tick_timer_next;
    end
  end

  // result shows the levels after this item
  always_comb begin
    gone_c = direction_positive_next ? signed'({1'b0, completed_steps_next})
                                     : -signed'({1'b0, completed_steps_next});
    gone_x = GW'(gone_c);
    res.step_level = (phase_next == PH_STEP) &&
                     (CMP_W'(tick_timer_next) < CMP_W'(pulse_width));
    res.dir_level  = direction_positive_next;
    res.done_res   = (phase_next == PH_IDLE);
    res.steps_gone = gone_x[STEPS_W-1:0];
  end

endmodule
`default_nettype wire

// ===== rtl/stepper_step_dir_pulse_generator.sv =====
`default_nettype none
// step/direction pulse generator, one tick or move command per input beat
// an input beat passes through the input register and then the result register
// throughput: one beat per cycle while the result side accepts beats; the motion state
//   register closes its loop through the next-state logic, so ticks stream with no gaps
// reset (rst, synchronous, active high): idle and done, direction positive,
//   step_period 1000, pulse_width 3, both stages empty
module stepper_step_dir_pulse_generator import stp_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input beats
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [23:0]          s_tdata,   // [23:0] steps
  input  wire logic                 s_tuser,   // [0] operation
  // result beats
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [31:0]               m_tdata,   // [0] step_level, [1] dir_level,
                                               // [2] done_res, [26:3] steps_gone
  // configuration writes
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [PERIOD_W-1:0]  cfg_data
);

  logic [PERIOD_W-1:0] step_period;
  logic [PULSE_W-1:0]  pulse_width;

  // input register
  logic                      in_valid_r;
  logic                      op_r;
  logic signed [STEPS_W-1:0] steps_r;

  logic        out_free;
  logic        adv;
  stp_result_t res;
  stp_result_t res_r;

  // output register empty or draining this cycle
  assign out_free = !m_tvalid || m_tready;
  // input register moves into the state update and result register
  assign adv      = in_valid_r && out_free;
  assign s_tready = !in_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_period <= STEP_PERIOD_RST;
      pulse_width <= PULSE_WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_STEP_PERIOD: step_period <= cfg_data;
        REG_PULSE_WIDTH: pulse_width <= cfg_data[PULSE_W-1:0];
        default: step_period <= step_period;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_r <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_r    <= s_tuser;
      steps_r <= signed'(s_tdata[STEPS_W-1:0]);
    end
  end

  stp_core #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (adv),
    .item_op     (op_r),
    .item_steps  (steps_r),
    .step_period (step_period),
    .pulse_width (pulse_width),
    .res         (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign m_tdata = {5'b0, res_r.steps_gone, res_r.done_res, res_r.dir_level, res_r.step_level};

  // a finished move never shows the step pin high
  a_done_no_pulse: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> !m_tdata[0])
    else $error("step pin high while done");

  // input only stalls when both stages are full and the output is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid_r && m_tvalid && !m_tready))
    else $error("input stalled without a full pipeline");

  // an item that moves forward produces a result beat next cycle
  a_adv_result: assert property (@(posedge clk) disable iff (rst)
    adv |=> m_tvalid)
    else $error("advanced item lost its result beat");

endmodule
`default_nettype wire

// ===== sim/tb_stepper_step_dir_pulse_generator.sv =====
`timescale 1ns / 1ps
module tb_stepper_step_dir_pulse_generator;
  import stp_pkg::*;

  localparam int CLK_HALF   = 4;
  localparam int PIPE_LAT   = 2;     // input reg plus result reg
  localparam int RAND_ITEMS = 500;   // beats wanted from the random part
  localparam longint SAT_MAX = (longint'(1) << (STEPS_W - 1)) - 1;

  // directed plan rows are either an input beat or a register write
  typedef enum logic [0:0] {
    ROW_BEAT = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic        op;      // operation for a beat, register index for a write
    logic [23:0] value;   // steps for a beat, write data for a write
    logic        typed;   // result typed in by hand
    stp_result_t res;
  } plan_row_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [23:0]          s_tdata;   // [23:0] steps
  logic                 s_tuser;   // [0] operation
  logic                 m_tvalid;
  logic                 m_tready;
  logic [31:0]          m_tdata;   // [0] step_level, [1] dir_level, [2] done_res,
                                   // [26:3] steps_gone
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [PERIOD_W-1:0]  cfg_data;

  stepper_step_dir_pulse_generator DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  // motion model: registers and state as the block should hold them
  logic [PERIOD_W-1:0]        mdl_period;
  logic [PULSE_W-1:0]         mdl_pulse;
  logic [STEPS_W-2:0]         mdl_target;
  logic [STEPS_W-2:0]         mdl_done_steps;
  logic                       mdl_dir_pos;
  logic                       mdl_last_pos;
  logic [TIMER_WIDTH_DEF-1:0] mdl_timer;
  phase_t                     mdl_phase;
  logic                       mdl_idle;

  stp_result_t pin_state_q[$];   // expected pin levels and counts, oldest first
  plan_row_t   plan_q[$];
  stp_result_t want_pins;
  int          mismatch_cnt;
  int          send_count;
  bit          send_calm;
  bit          recv_calm;
  int          recv_cycle;
  int          stall_left;

  // one beat through the motion model; returns the pin levels after it
  function automatic stp_result_t advance_motion(input logic op, input logic [23:0] steps);
    stp_result_t                r;
    longint                     delta;
    longint                     rem;
    longint                     merged;
    logic [PERIOD_W-1:0]        period_eff;
    logic [TIMER_WIDTH_DEF-1:0] t_next;
    delta = longint'($signed(steps));
    if (op == OP_MOVE) begin
      // a zero move leaves everything as it was
      if (delta != 0) begin
        if (mdl_idle) begin
          merged = delta;
        end else begin
          // remainder counts whole steps only, the partial one is dropped
          rem = longint'(mdl_target) - longint'(mdl_done_steps);
          if (rem < 0) rem = 0;
          merged = (mdl_dir_pos ? rem : -rem) + delta;
        end
        if (merged > SAT_MAX) merged = SAT_MAX;
        if (merged < -SAT_MAX) merged = -SAT_MAX;
        mdl_dir_pos    = merged > 0;
        mdl_target     = (STEPS_W - 1)'(merged < 0 ? -merged : merged);
        mdl_done_steps = '0;
        mdl_timer      = '0;
        if (mdl_target == 0) begin
          // merged to zero: direction goes negative, block becomes done
          mdl_idle  = 1'b1;
          mdl_phase = PH_IDLE;
        end else begin
          mdl_idle  = 1'b0;
          mdl_phase = (mdl_last_pos != mdl_dir_pos) ? PH_WAIT : PH_STEP;
        end
      end
    end else if (mdl_phase == PH_WAIT || mdl_phase == PH_STEP) begin
      period_eff = (mdl_period == 0) ? PERIOD_W'(1) : mdl_period;
      t_next     = mdl_timer + 1'b1;
      if (t_next >= period_eff || t_next == 0) begin
        mdl_timer = '0;
        if (mdl_phase == PH_WAIT) begin
          // reversal wait over, the new direction now counts as executed
          mdl_last_pos = mdl_dir_pos;
          mdl_phase    = PH_STEP;
        end else begin
          mdl_done_steps = mdl_done_steps + 1'b1;
          if (mdl_done_steps >= mdl_target) begin
            mdl_phase = PH_IDLE;
            mdl_idle  = 1'b1;
          end
        end
      end else begin
        mdl_timer = t_next;
      end
    end
    r.step_level = (mdl_phase == PH_STEP) && (mdl_timer < mdl_pulse);
    r.dir_level  = mdl_dir_pos;
    r.done_res   = mdl_idle;
    r.steps_gone = mdl_dir_pos ? {1'b0, mdl_done_steps} : -{1'b0, mdl_done_steps};
    return r;
  endfunction

  function automatic void add_beat(input logic op, input logic [23:0] steps);
    plan_row_t row;
    row       = '0;
    row.kind  = ROW_BEAT;
    row.op    = op;
    row.value = steps;
    plan_q.push_back(row);
  endfunction

  function automatic void add_typed(input logic op, input logic [23:0] steps, input logic st,
                                    input logic dr, input logic dn, input logic [23:0] gone);
    plan_row_t row;
    row                = '0;
    row.kind           = ROW_BEAT;
    row.op             = op;
    row.value          = steps;
    row.typed          = 1'b1;
    row.res.step_level = st;
    row.res.dir_level  = dr;
    row.res.done_res   = dn;
    row.res.steps_gone = gone;
    plan_q.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [PERIOD_W-1:0] val);
    plan_row_t row;
    row       = '0;
    row.kind  = ROW_CFG;
    row.op    = idx;
    row.value = 24'(val);
    plan_q.push_back(row);
  endfunction

  // gap lengths: mostly none or short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [23:0] rand_steps();
    int r;
    int mag;
    r = $urandom_range(0, 99);
    if (r < 62) begin
      mag = $urandom_range(1, 6);
      return $urandom_range(0, 1) ? 24'(mag) : 24'(-mag);
    end
    if (r < 70) return '0;
    if (r < 82) begin
      case ($urandom_range(0, 3))
        0:       return 24'h7FFFFF;
        1:       return 24'h800000;
        2:       return 24'h800001;
        default: return 24'hFFFFFF;
      endcase
    end
    return 24'($urandom());
  endfunction

  // drive one beat at the falling edge and hold it until accepted
  task automatic send_item(input logic op, input logic [23:0] steps, input logic typed,
                           input stp_result_t typed_res);
    int          gap;
    stp_result_t pred;
    send_count++;
    if (send_count % 90 == 0) send_calm = ~send_calm;
    gap = send_calm ? 0 : gap_len();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = steps;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = advance_motion(op, steps);
    pin_state_q.push_back(typed ? typed_res : pred);
    @(negedge clk);
  endtask

  // sender holds off until every result is back, then the pipe drains
  task automatic settle_idle();
    s_tvalid = 1'b0;
    while (pin_state_q.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PERIOD_W-1:0] val);
    settle_idle();
    cfg_we   = 1'b1;
    cfg_addr = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_STEP_PERIOD) mdl_period = val;
    else mdl_pulse = val[PULSE_W-1:0];
  endtask

  task automatic check_field(input string name, input logic [23:0] want_v,
                             input logic [23:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t ns: %s expected %0h, got %0h", $time, name, want_v, got_v);
      mismatch_cnt++;
    end
  endtask

  // result side: compare every accepted beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pin_state_q.size() == 0) begin
        $display("%0t ns: result beat with nothing expected, expected none, got %h",
                 $time, m_tdata);
        mismatch_cnt++;
      end else begin
        want_pins = pin_state_q.pop_front();
        check_field("step_level", 24'(want_pins.step_level), 24'(m_tdata[0]));
        check_field("dir_level", 24'(want_pins.dir_level), 24'(m_tdata[1]));
        check_field("done_res", 24'(want_pins.done_res), 24'(m_tdata[2]));
        check_field("steps_gone", want_pins.steps_gone, m_tdata[26:3]);
      end
    end
  end

  // receiver stalls, with calm stretches of steady ready
  always @(negedge clk) begin
    recv_cycle++;
    if (recv_cycle % 300 == 0) recv_calm = ~recv_calm;
    if (stall_left > 0) begin
      m_tready   = 1'b0;
      stall_left = stall_left - 1;
    end else begin
      m_tready = 1'b1;
      if (!recv_calm) stall_left = gap_len();
    end
  end

  initial begin
    #(4_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int          phase_no;
    int          phase_end;
    int          n;
    int          k;
    int          span;
    logic [PERIOD_W-1:0] per;
    logic [PULSE_W-1:0]  pw;
    clk      = 1'b0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = OP_TICK;
    m_tready = 1'b0;
    cfg_we   = 1'b0;
    cfg_addr = REG_STEP_PERIOD;
    cfg_data = '0;
    mismatch_cnt = 0;
    send_count   = 0;
    send_calm    = 1'b0;
    recv_calm    = 1'b0;
    recv_cycle   = 0;
    stall_left   = 0;

    mdl_period     = STEP_PERIOD_RST;
    mdl_pulse      = PULSE_WIDTH_RST;
    mdl_target     = '0;
    mdl_done_steps = '0;
    mdl_dir_pos    = 1'b1;
    mdl_last_pos   = 1'b1;
    mdl_timer      = '0;
    mdl_phase      = PH_IDLE;
    mdl_idle       = 1'b1;

    // directed plan, reset register values first
    add_typed(OP_TICK, 24'd0, 1'b0, 1'b1, 1'b1, 24'd0);   // idle tick after reset
    add_typed(OP_MOVE, 24'd0, 1'b0, 1'b1, 1'b1, 24'd0);   // zero move
    add_typed(OP_MOVE, 24'd2, 1'b1, 1'b1, 1'b0, 24'd0);   // step starts at once
    add_typed(OP_TICK, 24'd0, 1'b1, 1'b1, 1'b0, 24'd0);   // still inside the pulse
    add_typed(OP_MOVE, -24'sd2, 1'b0, 1'b0, 1'b1, 24'd0); // merges to zero
    add_cfg(REG_STEP_PERIOD, PERIOD_W'(4));
    add_cfg(REG_PULSE_WIDTH, PERIOD_W'(2));
    add_typed(OP_MOVE, 24'd3, 1'b1, 1'b1, 1'b0, 24'd0);
    repeat (4) add_beat(OP_TICK, 24'd0);                  // first step completes
    add_beat(OP_MOVE, -24'sd10);                          // reversal, wait period
    repeat (2) add_beat(OP_TICK, 24'd0);
    add_beat(OP_MOVE, 24'd9);                             // move abandons the wait
    add_beat(OP_TICK, 24'd0);
    repeat (2) add_beat(OP_MOVE, 24'h7FFFFF);             // saturates positive
    repeat (2) add_beat(OP_MOVE, 24'h800000);             // then saturates negative
    repeat (2) add_beat(OP_TICK, 24'd0);
    add_cfg(REG_STEP_PERIOD, PERIOD_W'(0));               // acts as one tick
    add_cfg(REG_PULSE_WIDTH, PERIOD_W'(0));               // pin never rises
    repeat (3) add_beat(OP_TICK, 24'd0);
    add_cfg(REG_PULSE_WIDTH, PERIOD_W'(255));             // pulse wider than period
    add_beat(OP_TICK, 24'd0);

    repeat (4) @(negedge clk);
    rst = 1'b0;

    foreach (plan_q[i]) begin
      if (plan_q[i].kind == ROW_CFG) begin
        write_reg(plan_q[i].op, plan_q[i].value[PERIOD_W-1:0]);
      end else begin
        send_item(plan_q[i].op, plan_q[i].value, plan_q[i].typed, plan_q[i].res);
      end
    end

    // random part: each phase drains fully before its new setting
    send_count = 0;
    phase_no   = 0;
    while (send_count < RAND_ITEMS) begin
      case (phase_no)
        0: begin
          per = '1;
          pw  = '1;
        end
        1: begin
          per = PERIOD_W'(1);
          pw  = PULSE_W'(1);
        end
        default: begin
          per = PERIOD_W'($urandom_range(2, 10));
          k   = $urandom_range(0, 7);
          if (k == 0) pw = '1;
          else if (k == 1) pw = '0;
          else pw = PULSE_W'($urandom_range(0, per + 1));
        end
      endcase
      write_reg(REG_STEP_PERIOD, per);
      write_reg(REG_PULSE_WIDTH, PERIOD_W'(pw));
      span      = (per < 12) ? 12 * (per + 1) + 4 : 30;
      phase_end = send_count + $urandom_range(40, 80);
      while (send_count < phase_end && send_count < RAND_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: any mix of ticks and moves
          n = $urandom_range(1, 8);
          repeat (n) send_item(1'($urandom()), 24'($urandom()), 1'b0, '0);
        end else begin
          // a move and a run of ticks, now and then cut short by another move
          send_item(OP_MOVE, rand_steps(), 1'b0, '0);
          n = $urandom_range(0, span);
          repeat (n) begin
            if ($urandom_range(0, 11) == 0) send_item(OP_MOVE, rand_steps(), 1'b0, '0);
            else send_item(OP_TICK, 24'($urandom()), 1'b0, '0);
          end
        end
      end
      phase_no++;
    end

    s_tvalid = 1'b0;
    while (pin_state_q.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 8) @(negedge clk);
    if (mismatch_cnt == 0 && pin_state_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
